[src/skh_pkg.sv]
// Shared types, constants and the per-stage step function of the key hash engine.
// Used by every module under src; depends on nothing.
package skh_pkg;

    localparam int KEY_LEN_W   = 16;
    localparam int LEN_W       = 16;
    localparam int HASH_W      = 32;
    localparam int GROUP_W     = 24;
    localparam int METHOD_W    = 3;
    localparam int MIX_STAGES  = 9;
    localparam int STEP_W      = 4;
    localparam int FIFO_DEPTH  = 32;
    localparam int FIFO_AW     = 5;
    localparam int FIFO_CW     = 6;

    localparam logic [METHOD_W-1:0] HM_JENKINS = 3'd0;
    localparam logic [METHOD_W-1:0] HM_HSIEH   = 3'd1;
    localparam logic [METHOD_W-1:0] HM_DJB2    = 3'd2;
    localparam logic [METHOD_W-1:0] HM_FNV0    = 3'd3;
    localparam logic [METHOD_W-1:0] HM_SDBM    = 3'd4;

    localparam logic CFG_METHOD = 1'b0;
    localparam logic CFG_SEED   = 1'b1;

    localparam logic [HASH_W-1:0] GOLDEN    = 32'h9e3779b9;
    localparam logic [HASH_W-1:0] DJB2_INIT = 32'd5381;

    localparam logic [3:0]       BLOCK_LAST  = 4'd11;
    localparam logic [LEN_W-1:0] BLOCK_BYTES = LEN_W'(12);

    typedef enum logic [1:0] {
        MODE_PASS,
        MODE_MIX,
        MODE_HSIEH
    } t_mode;

    typedef struct packed {
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic [HASH_W-1:0] c;
    } t_vec;

    // Result token that rides along the pipelines
    typedef struct packed {
        logic                vld;
        logic                err;
        logic                jen;
        logic [METHOD_W-1:0] method;
        t_vec                acc;
        logic [LEN_W-1:0]    len;
        logic [HASH_W-1:0]   hash;
        logic [GROUP_W-1:0]  group;
    } t_tag;

    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] a;
        logic [HASH_W-1:0] b;
        logic              err;
    } t_result;

    // One stage of work. Mix: one line of the three-word mix.
    // Hsieh finish: a = gathered bytes, b[1:0] = length mod 4, c = running hash.
    function automatic t_vec skh_step(input logic [STEP_W-1:0] idx, input t_mode mode,
                                      input t_vec v);
        t_vec              r;
        logic [HASH_W-1:0] h;
        r = v;
        h = v.c;
        case (mode)
            MODE_MIX: begin
                case (idx)
                    4'd0: r.a = (v.a - v.b - v.c) ^ (v.c >> 13);
                    4'd1: r.b = (v.b - v.c - v.a) ^ (v.a << 8);
                    4'd2: r.c = (v.c - v.a - v.b) ^ (v.b >> 13);
                    4'd3: r.a = (v.a - v.b - v.c) ^ (v.c >> 12);
                    4'd4: r.b = (v.b - v.c - v.a) ^ (v.a << 16);
                    4'd5: r.c = (v.c - v.a - v.b) ^ (v.b >> 5);
                    4'd6: r.a = (v.a - v.b - v.c) ^ (v.c >> 3);
                    4'd7: r.b = (v.b - v.c - v.a) ^ (v.a << 10);
                    4'd8: r.c = (v.c - v.a - v.b) ^ (v.b >> 15);
                    default: r = v;
                endcase
            end
            MODE_HSIEH: begin
                case (idx)
                    4'd0: begin
                        case (v.b[1:0])
                            2'd3, 2'd2: h = h + {16'b0, v.a[15:0]};
                            2'd1:       h = h + {24'b0, v.a[7:0]};
                            default:    h = h;
                        endcase
                    end
                    4'd1: begin
                        case (v.b[1:0])
                            2'd3:    h = (h ^ (h << 16)) ^ {6'b0, v.a[23:16], 18'b0};
                            2'd2:    h = h ^ (h << 11);
                            2'd1:    h = h ^ (h << 10);
                            default: h = h;
                        endcase
                    end
                    4'd2: begin
                        case (v.b[1:0])
                            2'd3:    h = h + (h >> 11);
                            2'd2:    h = h + (h >> 17);
                            2'd1:    h = h + (h >> 1);
                            default: h = h;
                        endcase
                    end
                    4'd3: begin
                        h = h ^ (h << 3);
                        h = h + (h >> 5);
                    end
                    4'd4: begin
                        h = h ^ (h << 4);
                        h = h + (h >> 17);
                    end
                    4'd5: begin
                        h = h ^ (h << 25);
                        h = h + (h >> 6);
                    end
                    default: h = v.c;
                endcase
                r.c = h;
            end
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

[src/selectable_key_hash_engine_top.sv]
// Channel    | valid       | ready       | word
// key in     | i_in_valid  | o_in_ready  | i_key_byte, i_first_of_key, i_last_of_key, i_key_length
// result out | o_out_valid | i_out_ready | o_hash_value, o_vector_a, o_vector_b, o_length_error
// config     | i_cfg_we    | (none)      | i_cfg_index, i_cfg_data
// One key byte is taken per cycle while o_in_ready is high; keys follow each other with no gap.
// A closing word's result passes 9 block-mix stages, one join register, 9 final-mix/finish
// stages and the result queue write.
// Block mixes run in a 9-stage pipeline, so a mix finishes before the next block closes.
// Input stalls only while all 32 result slots are reserved; reset is synchronous, active low.
module selectable_key_hash_engine_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [7:0]                   i_key_byte,
    input  logic                         i_first_of_key,
    input  logic                         i_last_of_key,
    input  logic [skh_pkg::KEY_LEN_W-1:0] i_key_length,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [skh_pkg::HASH_W-1:0]    o_hash_value,
    output logic [skh_pkg::HASH_W-1:0]    o_vector_a,
    output logic [skh_pkg::HASH_W-1:0]    o_vector_b,
    output logic                         o_length_error,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [skh_pkg::HASH_W-1:0]    i_cfg_data
);
    import skh_pkg::*;

    logic    w_accept;
    logic    w_ent_vld;
    t_mode   w_ent_mode;
    t_vec    w_ent_vec;
    t_tag    w_tok;
    t_vec    w_base;
    logic    w_m1_vld;
    t_vec    w_m1_vec;
    t_tag    w_m1_tag;
    logic    w_j_vld;
    t_mode   w_j_mode;
    t_vec    w_j_vec;
    t_tag    w_j_tag;
    logic    w_m2_vld;
    t_vec    w_m2_vec;
    t_tag    w_m2_tag;
    t_result w_res;
    t_result w_out;

    assign w_accept = i_in_valid && o_in_ready;

    skh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_key_byte   (i_key_byte),
        .i_first      (i_first_of_key),
        .i_last       (i_last_of_key),
        .i_key_length (i_key_length),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_base       (w_base),
        .o_ent_vld    (w_ent_vld),
        .o_ent_mode   (w_ent_mode),
        .o_ent_vec    (w_ent_vec),
        .o_tok        (w_tok)
    );

    skh_mix_pipe u_block_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_ent_vld),
        .i_mode  (w_ent_mode),
        .i_vec   (w_ent_vec),
        .i_tag   (w_tok),
        .o_vld   (w_m1_vld),
        .o_vec   (w_m1_vec),
        .o_tag   (w_m1_tag)
    );

    skh_join u_join (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_m1_vld),
        .i_vec   (w_m1_vec),
        .i_tag   (w_m1_tag),
        .o_base  (w_base),
        .o_vld   (w_j_vld),
        .o_mode  (w_j_mode),
        .o_vec   (w_j_vec),
        .o_tag   (w_j_tag)
    );

    skh_mix_pipe u_final_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_j_vld),
        .i_mode  (w_j_mode),
        .i_vec   (w_j_vec),
        .i_tag   (w_j_tag),
        .o_vld   (w_m2_vld),
        .o_vec   (w_m2_vec),
        .o_tag   (w_m2_tag)
    );

    // vector words are reported for the jenkins method only
    assign w_res.hash = w_m2_vec.c;
    assign w_res.a    = w_m2_tag.jen ? w_m2_vec.a : '0;
    assign w_res.b    = w_m2_tag.jen ? w_m2_vec.b : '0;
    assign w_res.err  = w_m2_tag.err;

    skh_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_reserve  (w_tok.vld),
        .i_wr       (w_m2_vld),
        .i_wr_data  (w_res),
        .o_in_ready (o_in_ready),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_data     (w_out)
    );

    assign o_hash_value   = w_out.hash;
    assign o_vector_a     = w_out.a;
    assign o_vector_b     = w_out.b;
    assign o_length_error = w_out.err;

endmodule

[src/skh_mix_pipe.sv]
// Nine-stage step pipeline: a mix line, finish step or pass per stage.
// Carries a result token alongside. Depends on skh_pkg.
module skh_mix_pipe (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  skh_pkg::t_mode i_mode,
    input  skh_pkg::t_vec  i_vec,
    input  skh_pkg::t_tag  i_tag,
    output logic          o_vld,
    output skh_pkg::t_vec  o_vec,
    output skh_pkg::t_tag  o_tag
);
    import skh_pkg::*;

    logic  r_vld  [MIX_STAGES];
    t_mode r_mode [MIX_STAGES];
    t_vec  r_vec  [MIX_STAGES];
    t_tag  r_tag  [MIX_STAGES];

    logic  s_vld  [MIX_STAGES];
    t_mode s_mode [MIX_STAGES];
    t_vec  s_vec  [MIX_STAGES];
    t_tag  s_tag  [MIX_STAGES];

    always_comb begin
        s_vld[0]  = i_vld;
        s_mode[0] = i_mode;
        s_vec[0]  = i_vec;
        s_tag[0]  = i_tag;
        for (int k = 1; k < MIX_STAGES; k++) begin
            s_vld[k]  = r_vld[k-1];
            s_mode[k] = r_mode[k-1];
            s_vec[k]  = r_vec[k-1];
            s_tag[k]  = r_tag[k-1];
        end
    end

    for (genvar k = 0; k < MIX_STAGES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
                r_tag[k] <= '0;
            end else begin
                r_vld[k] <= s_vld[k];
                r_tag[k] <= s_tag[k];
            end
        end

        always_ff @(posedge i_clk) begin
            r_mode[k] <= s_mode[k];
            r_vec[k]  <= skh_step(STEP_W'(k), s_mode[k], s_vec[k]);
        end
    end

    assign o_vld = r_vld[MIX_STAGES-1];
    assign o_vec = r_vec[MIX_STAGES-1];
    assign o_tag = r_tag[MIX_STAGES-1];

endmodule

[src/skh_front.sv]
// Key front end: configuration registers, per-key state, byte placement and
// the running hashes. Feeds block mixes and result tokens. Depends on skh_pkg.
module skh_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_accept,
    input  logic [7:0]                   i_key_byte,
    input  logic                         i_first,
    input  logic                         i_last,
    input  logic [skh_pkg::KEY_LEN_W-1:0] i_key_length,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [skh_pkg::HASH_W-1:0]    i_cfg_data,
    input  skh_pkg::t_vec                 i_base,
    output logic                         o_ent_vld,
    output skh_pkg::t_mode                o_ent_mode,
    output skh_pkg::t_vec                 o_ent_vec,
    output skh_pkg::t_tag                 o_tok
);
    import skh_pkg::*;

    logic [METHOD_W-1:0] r_hash_method;
    logic [HASH_W-1:0]   r_hash_seed;
    logic [METHOD_W-1:0] r_key_method, n_key_method;
    logic [LEN_W-1:0]    r_decl, n_decl;
    logic [LEN_W-1:0]    r_count, n_count;
    logic [LEN_W-1:0]    r_remain, n_remain;
    logic [3:0]          r_g, n_g;
    t_vec                r_acc, n_acc;
    logic [HASH_W-1:0]   r_hash, n_hash;
    logic [GROUP_W-1:0]  r_group, n_group;
    logic                r_overrun, n_overrun;
    logic                r_in_key, n_in_key;

    logic [LEN_W-1:0]    w_len;
    logic                w_in_key;
    logic                w_take_try;
    logic                w_take;
    logic                w_tail;
    logic [1:0]          w_lane;
    logic [5:0]          w_sh;
    logic [HASH_W-1:0]   w_k32;
    logic [HASH_W-1:0]   w_placed;
    logic                w_init;
    logic                w_blk;
    logic [15:0]         w_hi;
    logic [HASH_W-1:0]   w_tmp;
    logic [HASH_W-1:0]   h;

    always_comb begin
        w_len    = i_key_length[LEN_W-1:0];
        w_in_key = i_first | r_in_key;
        w_k32    = {24'b0, i_key_byte};

        // start a new key on a first word
        if (i_first) begin
            n_key_method = r_hash_method;
            n_decl       = w_len;
            n_count      = '0;
            n_remain     = w_len;
            n_g          = '0;
            n_acc        = '0;
            n_group      = '0;
            n_overrun    = 1'b0;
            case (r_hash_method)
                HM_HSIEH: n_hash = HASH_W'(w_len);
                HM_DJB2:  n_hash = DJB2_INIT;
                default:  n_hash = '0;
            endcase
        end else begin
            n_key_method = r_key_method;
            n_decl       = r_decl;
            n_count      = r_count;
            n_remain     = r_remain;
            n_g          = r_g;
            n_acc        = r_acc;
            n_group      = r_group;
            n_overrun    = r_overrun;
            n_hash       = r_hash;
        end

        w_take_try = i_accept && w_in_key && !(i_first && (w_len == '0));
        w_take     = w_take_try && (n_count < n_decl);

        w_tail   = n_remain < BLOCK_BYTES;
        w_lane   = n_g[3:2];
        w_sh     = {1'b0, n_g[1:0], 3'b000} +
                   ((w_tail && (w_lane == 2'd2)) ? 6'd8 : 6'd0);
        w_placed = w_k32 << w_sh;
        w_blk    = w_take && (n_key_method == HM_JENKINS) && (n_g == BLOCK_LAST) && !w_tail;
        w_init   = i_accept && i_first && (r_hash_method == HM_JENKINS);

        h     = n_hash;
        w_hi  = '0;
        w_tmp = '0;

        o_ent_vld  = 1'b0;
        o_ent_mode = MODE_PASS;
        o_ent_vec  = '{a: GOLDEN, b: GOLDEN, c: r_hash_seed};
        if (w_init) begin
            o_ent_vld = 1'b1;
        end

        if (w_take_try && !w_take) begin
            n_overrun = 1'b1;
        end

        if (w_take) begin
            case (n_key_method)
                HM_JENKINS: begin
                    case (w_lane)
                        2'd0:    n_acc.a = n_acc.a | w_placed;
                        2'd1:    n_acc.b = n_acc.b | w_placed;
                        default: n_acc.c = n_acc.c | w_placed;
                    endcase
                    if (w_blk) begin
                        // hand the finished block to the mix pipeline
                        o_ent_vld  = 1'b1;
                        o_ent_mode = MODE_MIX;
                        o_ent_vec  = '{a: i_base.a + n_acc.a,
                                       b: i_base.b + n_acc.b,
                                       c: i_base.c + n_acc.c};
                        n_acc      = '0;
                    end
                end
                HM_HSIEH: begin
                    case (n_count[1:0])
                        2'd0: n_group[7:0]   = n_group[7:0] | i_key_byte;
                        2'd1: n_group[15:8]  = n_group[15:8] | i_key_byte;
                        2'd2: n_group[23:16] = n_group[23:16] | i_key_byte;
                        default: begin
                            w_hi    = {i_key_byte, n_group[23:16]};
                            h       = h + {16'b0, n_group[15:0]};
                            w_tmp   = {5'b0, w_hi, 11'b0} ^ h;
                            h       = (h << 16) ^ w_tmp;
                            h       = h + (h >> 11);
                            n_group = '0;
                        end
                    endcase
                end
                HM_DJB2: h = ((h << 5) + h) ^ w_k32;
                HM_FNV0: h = (h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24)) ^ w_k32;
                HM_SDBM: h = w_k32 + (h << 6) + (h << 16) - h;
                default: h = n_hash;
            endcase
            n_hash   = h;
            n_count  = n_count + LEN_W'(1);
            n_g      = (n_g == BLOCK_LAST) ? 4'd0 : n_g + 4'd1;
            n_remain = (n_g == 4'd0) ? n_remain - BLOCK_BYTES : n_remain;
        end

        n_in_key = w_in_key && !i_last;

        o_tok.vld    = i_accept && w_in_key && i_last;
        o_tok.err    = n_overrun || (n_count != n_decl);
        o_tok.jen    = n_key_method == HM_JENKINS;
        o_tok.method = n_key_method;
        o_tok.acc    = n_acc;
        o_tok.len    = n_decl;
        o_tok.hash   = n_hash;
        o_tok.group  = n_group;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_method <= HM_JENKINS;
            r_hash_seed   <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_METHOD) begin
                r_hash_method <= i_cfg_data[METHOD_W-1:0];
            end else begin
                r_hash_seed <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_method <= HM_JENKINS;
            r_decl       <= '0;
            r_count      <= '0;
            r_remain     <= '0;
            r_g          <= '0;
            r_acc        <= '0;
            r_hash       <= '0;
            r_group      <= '0;
            r_overrun    <= 1'b0;
            r_in_key     <= 1'b0;
        end else if (i_accept && w_in_key) begin
            r_key_method <= n_key_method;
            r_decl       <= n_decl;
            r_count      <= n_count;
            r_remain     <= n_remain;
            r_g          <= n_g;
            r_acc        <= n_acc;
            r_hash       <= n_hash;
            r_group      <= n_group;
            r_overrun    <= n_overrun;
            r_in_key     <= n_in_key;
        end
    end

`ifndef SYNTH
    // a key start never closes a block, so the two entries never collide
    a_one_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_init && w_blk))
        else $error("key start and block mix in the same cycle");
`endif

endmodule

[src/skh_join.sv]
// Holds the mixed a,b,c of the open key and forms the final mix or finish
// input for each result token. Depends on skh_pkg.
module skh_join (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_vld,
    input  skh_pkg::t_vec  i_vec,
    input  skh_pkg::t_tag  i_tag,
    output skh_pkg::t_vec  o_base,
    output logic          o_vld,
    output skh_pkg::t_mode o_mode,
    output skh_pkg::t_vec  o_vec,
    output skh_pkg::t_tag  o_tag
);
    import skh_pkg::*;

    t_vec  r_base;
    logic  r_vld;
    t_mode r_mode;
    t_vec  r_vec;
    t_tag  r_tag;

    t_vec  w_base;
    t_mode n_mode;
    t_vec  n_vec;
    t_tag  n_tag;

    always_comb begin
        // a block mix leaving the pipeline this cycle is newer than the held copy
        w_base = i_vld ? i_vec : r_base;

        n_tag     = '0;
        n_tag.vld = i_tag.vld;
        n_tag.err = i_tag.err;
        n_mode    = MODE_PASS;
        n_vec     = '0;
        if (!i_tag.err) begin
            case (i_tag.method)
                HM_JENKINS: begin
                    n_tag.jen = 1'b1;
                    n_mode    = MODE_MIX;
                    n_vec.a   = w_base.a + i_tag.acc.a;
                    n_vec.b   = w_base.b + i_tag.acc.b;
                    n_vec.c   = w_base.c + i_tag.acc.c + HASH_W'(i_tag.len);
                end
                HM_HSIEH: begin
                    n_mode  = MODE_HSIEH;
                    n_vec.a = HASH_W'(i_tag.group);
                    n_vec.b = HASH_W'(i_tag.len[1:0]);
                    n_vec.c = i_tag.hash;
                end
                default: begin
                    n_vec.c = i_tag.hash;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_vld) begin
            r_base <= i_vec;
        end
        r_mode <= n_mode;
        r_vec  <= n_vec;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
            r_tag <= '0;
        end else begin
            r_vld <= i_tag.vld;
            r_tag <= n_tag;
        end
    end

    assign o_base = r_base;
    assign o_vld  = r_vld;
    assign o_mode = r_mode;
    assign o_vec  = r_vec;
    assign o_tag  = r_tag;

endmodule

[src/skh_out_fifo.sv]
// Result queue with slot reservation: a slot is reserved when a closing word
// is accepted and freed when the result word is taken. Depends on skh_pkg.
module skh_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_reserve,
    input  logic             i_wr,
    input  skh_pkg::t_result  i_wr_data,
    output logic             o_in_ready,
    output logic             o_valid,
    input  logic             i_ready,
    output skh_pkg::t_result  o_data
);
    import skh_pkg::*;

    t_result              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_fill;
    logic [FIFO_CW-1:0]   r_credit;
    logic                 w_pop;

    assign o_valid    = r_fill != '0;
    assign w_pop      = o_valid && i_ready;
    assign o_data     = r_mem[r_rd_ptr];
    assign o_in_ready = r_credit != FIFO_CW'(FIFO_DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
            r_credit <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_fill   <= r_fill + FIFO_CW'(i_wr) - FIFO_CW'(w_pop);
            r_credit <= r_credit + FIFO_CW'(i_reserve) - FIFO_CW'(w_pop);
        end
    end

`ifndef SYNTH
    a_fill_le_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_credit)
        else $error("stored results exceed reserved slots");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_wr && (r_fill == FIFO_CW'(FIFO_DEPTH))))
        else $error("result written into a full queue");
    a_credit_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_reserve && !w_pop) |=> $stable(r_credit))
        else $error("slot count moved without reserve or take");
`endif

endmodule

[sim/selectable_key_hash_engine_top_tb.sv]
// Self-checking testbench for selectable_key_hash_engine_top: a directed table, then random keys.
// Predicts untyped results in place (all five methods); checks each output word in order.
// Depends on skh_pkg and the RTL under src.
module selectable_key_hash_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import skh_pkg::*;

    localparam logic [METHOD_W-1:0] HM_RSVD5 = 3'd5;
    localparam logic [METHOD_W-1:0] HM_RSVD7 = 3'd7;

    localparam int DIR_ROWS        = 24;
    localparam int NUM_PHASES      = 12;
    localparam int ITEMS_PER_PHASE = 60;
    localparam int CALM_PHASE      = 4;
    localparam int PRESS_PHASE     = 6;
    localparam int PRESS_HOLD      = 400;
    localparam int SETTLE_CYCLES   = 30;
    localparam int IDLE_PCT        = 37;

    localparam t_result R_NONE    = '0;
    localparam t_result R_LEN_ERR = '{hash: '0, a: '0, b: '0, err: 1'b1};

    typedef struct packed {
        logic [METHOD_W-1:0]  meth;
        logic [HASH_W-1:0]    seed;
        logic [7:0]           kb;
        logic                 first;
        logic                 last;
        logic [KEY_LEN_W-1:0] klen;
        logic                 chk;
        t_result              res;
    } t_row;

    // chk marks rows whose result is typed in; the rest go through the predictor
    localparam t_row DIR_TAB [DIR_ROWS] = '{
        '{HM_JENKINS, 32'h0,        8'h55, 1'b0, 1'b1, 16'h0000, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'hAA, 1'b1, 1'b1, 16'h0000, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'h00, 1'b1, 1'b0, 16'h0003, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'hFF, 1'b0, 1'b0, 16'hFFFF, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'h80, 1'b0, 1'b1, 16'h0000, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'h12, 1'b1, 1'b1, 16'h0002, 1'b1, R_LEN_ERR},
        '{HM_JENKINS, 32'h0,        8'h34, 1'b1, 1'b0, 16'h0001, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'h56, 1'b0, 1'b1, 16'h0000, 1'b1, R_LEN_ERR},
        '{HM_JENKINS, 32'h0,        8'hFF, 1'b1, 1'b1, 16'hFFFF, 1'b1, R_LEN_ERR},
        '{HM_JENKINS, 32'h0,        8'h01, 1'b1, 1'b0, 16'h0005, 1'b0, R_NONE},
        '{HM_JENKINS, 32'h0,        8'h02, 1'b1, 1'b1, 16'h0001, 1'b0, R_NONE},
        '{HM_JENKINS, 32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 16'h0001, 1'b0, R_NONE},
        '{HM_HSIEH,   32'hFFFFFFFF, 8'h00, 1'b1, 1'b1, 16'h0000, 1'b1, R_NONE},
        '{HM_HSIEH,   32'hFFFFFFFF, 8'hAB, 1'b1, 1'b0, 16'h0003, 1'b0, R_NONE},
        '{HM_HSIEH,   32'hFFFFFFFF, 8'hCD, 1'b0, 1'b0, 16'h0000, 1'b0, R_NONE},
        '{HM_HSIEH,   32'hFFFFFFFF, 8'hEF, 1'b0, 1'b1, 16'h0000, 1'b0, R_NONE},
        '{HM_DJB2,    32'hFFFFFFFF, 8'h00, 1'b1, 1'b1, 16'h0001, 1'b1,
          '{hash: 32'd177573, a: '0, b: '0, err: 1'b0}},
        '{HM_DJB2,    32'hFFFFFFFF, 8'h77, 1'b1, 1'b0, 16'h0000, 1'b0, R_NONE},
        '{HM_DJB2,    32'hFFFFFFFF, 8'h88, 1'b0, 1'b1, 16'h0000, 1'b1, R_LEN_ERR},
        '{HM_FNV0,    32'hFFFFFFFF, 8'h3C, 1'b1, 1'b1, 16'h0000, 1'b1, R_NONE},
        '{HM_FNV0,    32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 16'h0001, 1'b1,
          '{hash: 32'd255, a: '0, b: '0, err: 1'b0}},
        '{HM_SDBM,    32'hFFFFFFFF, 8'hFF, 1'b1, 1'b1, 16'h0001, 1'b1,
          '{hash: 32'd255, a: '0, b: '0, err: 1'b0}},
        '{HM_RSVD7,   32'hFFFFFFFF, 8'h5A, 1'b1, 1'b1, 16'h0001, 1'b1, R_NONE},
        '{HM_RSVD5,   32'hFFFFFFFF, 8'h00, 1'b1, 1'b1, 16'h0002, 1'b1, R_LEN_ERR}
    };

    localparam logic [METHOD_W-1:0] PHASE_METH [NUM_PHASES] = '{
        HM_JENKINS, HM_HSIEH, HM_DJB2, HM_FNV0, HM_SDBM, HM_JENKINS,
        HM_JENKINS, HM_HSIEH, HM_RSVD7, HM_DJB2, HM_SDBM, HM_JENKINS
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [7:0]            i_key_byte;
    logic                  i_first_of_key;
    logic                  i_last_of_key;
    logic [KEY_LEN_W-1:0]  i_key_length;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [HASH_W-1:0]     o_hash_value;
    logic [HASH_W-1:0]     o_vector_a;
    logic [HASH_W-1:0]     o_vector_b;
    logic                  o_length_error;
    logic                  i_cfg_we;
    logic                  i_cfg_index;
    logic [HASH_W-1:0]     i_cfg_data;

    // Register copies and the state of the key being hashed
    logic [METHOD_W-1:0]   reg_method;
    logic [HASH_W-1:0]     reg_seed;
    logic [HASH_W-1:0]     acc_a, acc_b, acc_c;
    logic [GROUP_W-1:0]    part_grp;
    logic [LEN_W-1:0]      taken_cnt;
    logic [LEN_W-1:0]      decl_len;
    logic                  key_open;
    logic                  key_over;
    logic [METHOD_W-1:0]   key_meth;

    t_result               hash_due [$];
    int                    fail_cnt;
    int                    items_left;
    int                    rx_hold;
    bit                    in_idles;
    bit                    out_idles;

    selectable_key_hash_engine_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_key_byte     (i_key_byte),
        .i_first_of_key (i_first_of_key),
        .i_last_of_key  (i_last_of_key),
        .i_key_length   (i_key_length),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_hash_value   (o_hash_value),
        .o_vector_a     (o_vector_a),
        .o_vector_b     (o_vector_b),
        .o_length_error (o_length_error),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_vec mix_words(input t_vec v);
        logic [HASH_W-1:0] a, b, c;
        t_vec              r;
        a = v.a;
        b = v.b;
        c = v.c;
        a = (a - b - c) ^ (c >> 13);
        b = (b - c - a) ^ (a << 8);
        c = (c - a - b) ^ (b >> 13);
        a = (a - b - c) ^ (c >> 12);
        b = (b - c - a) ^ (a << 16);
        c = (c - a - b) ^ (b >> 5);
        a = (a - b - c) ^ (c >> 3);
        b = (b - c - a) ^ (a << 10);
        c = (c - a - b) ^ (b >> 15);
        r.a = a;
        r.b = b;
        r.c = c;
        return r;
    endfunction

    function automatic logic [HASH_W-1:0] hsieh_final(input logic [HASH_W-1:0] hin,
                                                      input logic [GROUP_W-1:0] grp,
                                                      input logic [LEN_W-1:0] len);
        logic [HASH_W-1:0] h;
        h = hin;
        if (len == '0)
            return '0;
        case (len[1:0])
            2'd3: begin
                h = h + {16'b0, grp[15:0]};
                h = h ^ (h << 16);
                h = h ^ {6'b0, grp[23:16], 18'b0};
                h = h + (h >> 11);
            end
            2'd2: begin
                h = h + {16'b0, grp[15:0]};
                h = h ^ (h << 11);
                h = h + (h >> 17);
            end
            2'd1: begin
                h = h + {24'b0, grp[7:0]};
                h = h ^ (h << 10);
                h = h + (h >> 1);
            end
            default: ;
        endcase
        h = h ^ (h << 3);
        h = h + (h >> 5);
        h = h ^ (h << 4);
        h = h + (h >> 17);
        h = h ^ (h << 25);
        h = h + (h >> 6);
        return h;
    endfunction

    task automatic open_key(input logic [LEN_W-1:0] len);
        key_meth  = reg_method;
        decl_len  = len;
        taken_cnt = '0;
        part_grp  = '0;
        key_over  = 1'b0;
        key_open  = 1'b1;
        acc_a     = '0;
        acc_b     = '0;
        acc_c     = '0;
        case (key_meth)
            HM_JENKINS: begin
                acc_a = GOLDEN;
                acc_b = GOLDEN;
                acc_c = reg_seed;
            end
            HM_HSIEH: acc_c = {16'b0, len};
            HM_DJB2:  acc_c = DJB2_INIT;
            default: ;
        endcase
    endtask

    task automatic absorb_byte(input logic [7:0] k);
        logic [HASH_W-1:0] kw, h, lo, hi, tmp;
        logic [LEN_W-1:0]  pos, blk_start;
        logic [3:0]        g;
        logic [5:0]        sh;
        logic              tail;
        t_vec              v;
        kw  = {24'b0, k};
        pos = taken_cnt;
        h   = acc_c;
        case (key_meth)
            HM_JENKINS: begin
                g         = 4'(pos % 16'd12);
                blk_start = pos - {12'b0, g};
                tail      = (decl_len - blk_start) < BLOCK_BYTES;
                sh        = {1'b0, g[1:0], 3'b000};
                // short final block: c lane moves up one byte, leaving its low byte clear for the length
                if (tail && g[3:2] == 2'd2)
                    sh = sh + 6'd8;
                case (g[3:2])
                    2'd0:    acc_a = acc_a + (kw << sh);
                    2'd1:    acc_b = acc_b + (kw << sh);
                    default: acc_c = acc_c + (kw << sh);
                endcase
                if (g == BLOCK_LAST && !tail) begin
                    v.a   = acc_a;
                    v.b   = acc_b;
                    v.c   = acc_c;
                    v     = mix_words(v);
                    acc_a = v.a;
                    acc_b = v.b;
                    acc_c = v.c;
                end
            end
            HM_HSIEH: begin
                if (pos[1:0] != 2'd3) begin
                    part_grp = part_grp | 24'(kw << {pos[1:0], 3'b000});
                end else begin
                    lo       = {16'b0, part_grp[15:0]};
                    hi       = {16'b0, k, part_grp[23:16]};
                    h        = h + lo;
                    tmp      = (hi << 11) ^ h;
                    h        = (h << 16) ^ tmp;
                    h        = h + (h >> 11);
                    part_grp = '0;
                end
                acc_c = h;
            end
            HM_DJB2: acc_c = ((h << 5) + h) ^ kw;
            HM_FNV0: begin
                h     = h + (h << 1) + (h << 4) + (h << 7) + (h << 8) + (h << 24);
                acc_c = h ^ kw;
            end
            HM_SDBM: acc_c = kw + (h << 6) + (h << 16) - h;
            default: ;
        endcase
        taken_cnt = pos + 1'b1;
    endtask

    task automatic hash_word(input logic [7:0] k, input logic first, input logic last,
                             input logic [KEY_LEN_W-1:0] len, output bit has,
                             output t_result res);
        t_vec v;
        has = 1'b0;
        res = '0;
        if (first)
            open_key(len);
        if (key_open) begin
            // an empty key's opening word carries no byte
            if (!(first && decl_len == '0)) begin
                if (taken_cnt < decl_len)
                    absorb_byte(k);
                else
                    key_over = 1'b1;
            end
            if (last) begin
                has     = 1'b1;
                res.err = key_over || (taken_cnt != decl_len);
                if (!res.err) begin
                    case (key_meth)
                        HM_JENKINS: begin
                            acc_c    = acc_c + {16'b0, decl_len};
                            v.a      = acc_a;
                            v.b      = acc_b;
                            v.c      = acc_c;
                            v        = mix_words(v);
                            acc_a    = v.a;
                            acc_b    = v.b;
                            acc_c    = v.c;
                            res.hash = v.c;
                            res.a    = v.a;
                            res.b    = v.b;
                        end
                        HM_HSIEH:                   res.hash = hsieh_final(acc_c, part_grp,
                                                                           decl_len);
                        HM_DJB2, HM_FNV0, HM_SDBM: res.hash = acc_c;
                        default: ;
                    endcase
                end
                key_open = 1'b0;
            end
        end
    endtask

    // Offer one word, hold it until taken, then predict from what was accepted
    task automatic send_word(input logic [7:0] k, input logic first, input logic last,
                             input logic [KEY_LEN_W-1:0] len, input bit typed,
                             input t_result typed_res);
        bit      has;
        t_result res;
        @(negedge i_clk);
        while (in_idles && $urandom_range(0, 99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_key_byte     <= k;
        i_first_of_key <= first;
        i_last_of_key  <= last;
        i_key_length   <= len;
        do
            @(posedge i_clk);
        while (!o_in_ready);
        hash_word(k, first, last, len, has, res);
        if (has)
            hash_due.push_back(typed ? typed_res : res);
    endtask

    // Drop valid, wait out every pending result and the pipeline behind it
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (hash_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [HASH_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        if (idx == CFG_METHOD)
            reg_method = val[METHOD_W-1:0];
        else
            reg_seed = val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic send_key(input bit short_only);
        int  pick;
        int  len;
        int  decl;
        int  n;
        bit  close;
        bit  noise;
        bit  first;
        pick  = $urandom_range(0, 99);
        close = 1'b1;
        noise = 1'b0;
        if (short_only) begin
            len = $urandom_range(0, 2);
        end else begin
            len = $urandom_range(0, 99);
            if (len < 10)
                len = 0;
            else if (len < 80)
                len = $urandom_range(1, 16);
            else if (len < 95)
                len = $urandom_range(17, 40);
            else
                len = $urandom_range(41, 64);
        end
        if (pick < 82) begin
            decl = len;
            n    = (len == 0) ? 1 : len;
        end else if (pick < 86) begin
            n    = $urandom_range(1, 8);
            decl = n + $urandom_range(1, 3);
        end else if (pick < 90) begin
            decl = $urandom_range(0, 8);
            n    = ((decl == 0) ? 1 : decl) + $urandom_range(1, 3);
        end else if (pick < 94) begin
            // abandoned: the next key start cuts it off
            decl  = $urandom_range(2, 20);
            n     = $urandom_range(1, decl - 1);
            close = 1'b0;
        end else if (pick < 97) begin
            decl  = 0;
            n     = $urandom_range(1, 3);
            noise = 1'b1;
        end else begin
            decl = $urandom_range(0, 65535);
            n    = $urandom_range(1, 3);
        end
        for (int i = 0; i < n; i++) begin
            first = !noise && (i == 0);
            send_word(8'($urandom_range(0, 255)), first,
                      noise ? 1'($urandom_range(0, 1)) : (close && i == n - 1),
                      first ? 16'(decl) : 16'($urandom_range(0, 65535)), 1'b0, R_NONE);
            if (!noise)
                items_left--;
        end
    endtask

    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold > 0) begin
                i_out_ready <= 1'b0;
                rx_hold--;
            end else if (out_idles && $urandom_range(0, 99) < IDLE_PCT) begin
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (hash_due.size() == 0) begin
                $display("%0t: result with none expected: hash %h a %h b %h err %b",
                         $time, o_hash_value, o_vector_a, o_vector_b, o_length_error);
                fail_cnt++;
            end else begin
                want = hash_due.pop_front();
                if (o_hash_value !== want.hash) begin
                    $display("%0t: hash_value expected %h actual %h",
                             $time, want.hash, o_hash_value);
                    fail_cnt++;
                end
                if (o_vector_a !== want.a) begin
                    $display("%0t: vector_a expected %h actual %h", $time, want.a, o_vector_a);
                    fail_cnt++;
                end
                if (o_vector_b !== want.b) begin
                    $display("%0t: vector_b expected %h actual %h", $time, want.b, o_vector_b);
                    fail_cnt++;
                end
                if (o_length_error !== want.err) begin
                    $display("%0t: length_error expected %b actual %b",
                             $time, want.err, o_length_error);
                    fail_cnt++;
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_key_byte     = '0;
        i_first_of_key = 1'b0;
        i_last_of_key  = 1'b0;
        i_key_length   = '0;
        i_cfg_we       = 1'b0;
        i_cfg_index    = CFG_METHOD;
        i_cfg_data     = '0;
        reg_method     = HM_JENKINS;
        reg_seed       = '0;
        acc_a          = '0;
        acc_b          = '0;
        acc_c          = '0;
        part_grp       = '0;
        taken_cnt      = '0;
        decl_len       = '0;
        key_open       = 1'b0;
        key_over       = 1'b0;
        key_meth       = HM_JENKINS;
        fail_cnt       = 0;
        items_left     = 0;
        rx_hold        = 0;
        in_idles       = 1'b1;
        out_idles      = 1'b1;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIR_TAB[r].meth != reg_method || DIR_TAB[r].seed != reg_seed) begin
                settle();
                if (DIR_TAB[r].meth != reg_method)
                    write_reg(CFG_METHOD, {29'b0, DIR_TAB[r].meth});
                if (DIR_TAB[r].seed != reg_seed)
                    write_reg(CFG_SEED, DIR_TAB[r].seed);
            end
            send_word(DIR_TAB[r].kb, DIR_TAB[r].first, DIR_TAB[r].last, DIR_TAB[r].klen,
                      DIR_TAB[r].chk, DIR_TAB[r].res);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            settle();
            write_reg(CFG_METHOD, {29'b0, PHASE_METH[p]});
            write_reg(CFG_SEED, (p == 0) ? 32'h0 : (p == 5) ? 32'hFFFFFFFF : $urandom());
            in_idles  = (p != CALM_PHASE);
            out_idles = (p != CALM_PHASE);
            // stall the result side long enough for the block to back up its input
            if (p == PRESS_PHASE)
                rx_hold = PRESS_HOLD;
            items_left = ITEMS_PER_PHASE;
            while (items_left > 0)
                send_key(p == PRESS_PHASE);
            if (key_open)
                send_word(8'($urandom_range(0, 255)), 1'b0, 1'b1,
                          16'($urandom_range(0, 65535)), 1'b0, R_NONE);
        end

        settle();
        if (fail_cnt == 0 && hash_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

[sim.f]
src/skh_pkg.sv
src/skh_mix_pipe.sv
src/skh_front.sv
src/skh_join.sv
src/skh_out_fifo.sv
src/selectable_key_hash_engine_top.sv
sim/selectable_key_hash_engine_top_tb.sv
